// ===== rtl/uripct_pkg.sv =====
`timescale 1ns / 1ps

package uripct_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [3:0] LOW_NIBBLE = 4'hF;
  localparam int unsigned GRP_MAX   = 3;

  // Result group produced by one accepted input byte (byte 0 goes out first)
  typedef struct packed {
    logic [1:0]              cnt;
    logic [GRP_MAX-1:0][7:0] bytes;
    logic                    last;
  } grp_t;

  // Hex digit of either case
  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66);
  endfunction

  // Value of a hex digit; letters have bit 6 set and low nibble 1..6
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    hex_val = b[6] ? (b[3:0] + 4'd9) : b[3:0];
  endfunction

  function automatic logic unreserved(input logic [7:0] b);
    unreserved = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
                 (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h2E ||
                 b == 8'h5F || b == 8'h7E;
  endfunction

  // Uppercase hex character for a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
  endfunction

endpackage

// ===== rtl/uripct_ifs.sv =====
`timescale 1ns / 1ps

// Source byte stream
interface uripct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

// Converted byte stream
interface uripct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink (input valid, out_byte, out_last, output ready);
endinterface

// ===== rtl/uripct_conv.sv =====
`timescale 1ns / 1ps

// Mode register, escape hold state and the per-byte conversion logic.
module uripct_conv (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              take,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output uripct_pkg::grp_t  grp
);
  import uripct_pkg::*;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_t;

  logic       mode;
  held_t      held_count;
  held_t      held_count_next;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;
  logic       new_pct;

  // A '%' that is not the last byte starts a new escape
  assign new_pct = (in_byte == PCT_CHAR) && !in_last;

  // Conversion of one byte into up to three result bytes
  always_comb begin
    held_count_next = HELD_NONE;
    held_digit_next = held_digit;
    grp.cnt         = 2'd0;
    grp.bytes       = '0;
    grp.last        = in_last;
    if (!mode) begin
      if (unreserved(in_byte)) begin
        grp.cnt      = 2'd1;
        grp.bytes[0] = in_byte;
      end else begin
        grp.cnt      = 2'd3;
        grp.bytes[0] = PCT_CHAR;
        grp.bytes[1] = hex_char(in_byte[7:4] & LOW_NIBBLE);
        grp.bytes[2] = hex_char(in_byte[3:0] & LOW_NIBBLE);
      end
    end else begin
      case (held_count)
        HELD_PCT: begin
          grp.bytes[0] = PCT_CHAR;
          grp.bytes[1] = in_byte;
          if (is_hex(in_byte) && !in_last) begin
            held_count_next = HELD_DIGIT;
            held_digit_next = in_byte;
          end else if (!is_hex(in_byte) && new_pct) begin
            held_count_next = HELD_PCT;
            grp.cnt         = 2'd1;
          end else begin
            grp.cnt = 2'd2;
          end
        end
        HELD_DIGIT: begin
          if (is_hex(in_byte)) begin
            grp.cnt      = 2'd1;
            grp.bytes[0] = {hex_val(held_digit), hex_val(in_byte)};
          end else begin
            grp.bytes[0] = PCT_CHAR;
            grp.bytes[1] = held_digit;
            grp.bytes[2] = in_byte;
            if (new_pct) begin
              held_count_next = HELD_PCT;
              grp.cnt         = 2'd2;
            end else begin
              grp.cnt = 2'd3;
            end
          end
        end
        default: begin
          grp.bytes[0] = in_byte;
          if (new_pct) begin
            held_count_next = HELD_PCT;
          end else begin
            grp.cnt = 2'd1;
          end
        end
      endcase
    end
  end

  // Mode and hold state; a mode write drops anything held
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      held_count <= HELD_NONE;
      held_digit <= '0;
    end else if (cfg_we) begin
      mode       <= cfg_wdata;
      held_count <= HELD_NONE;
    end else if (take) begin
      held_count <= held_count_next;
      held_digit <= held_digit_next;
    end
  end

`ifndef SYNTHESIS
  // Encode mode never holds bytes
  a_encode_no_hold: assert property (@(posedge clk) disable iff (rst)
    !mode |-> held_count == HELD_NONE)
    else $error("hold state set in encode mode");

  // A held digit is always a hex digit
  a_digit_hex: assert property (@(posedge clk) disable iff (rst)
    held_count == HELD_DIGIT |-> is_hex(held_digit))
    else $error("held digit is not hex");

  // A config write always clears the hold state
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> held_count == HELD_NONE)
    else $error("hold state survived mode write");
`endif

endmodule

// ===== rtl/uri_percent_codec.sv =====
`timescale 1ns / 1ps
// A result group is registered; its first byte appears in the cycle after its
// input byte's transfer. Output runs at one byte per cycle while the sink is
// ready. A new input byte is taken when no group is pending or as the final
// byte of a group goes out. Decode bytes that are only held give no output.
// Reset (rst, synchronous, active high): mode = encode, nothing held, no output.
module uri_percent_codec (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  uripct_in_if.sink        src,
  uripct_out_if.source     dst
);
  import uripct_pkg::*;

  grp_t                    grp_new;
  logic                    take;
  logic                    fin;
  logic                    g_valid;
  logic [1:0]              g_cnt;
  logic [1:0]              g_idx;
  logic [GRP_MAX-1:0][7:0] g_bytes;
  logic                    g_last;

  uripct_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .in_byte   (src.in_byte),
    .in_last   (src.in_last),
    .grp       (grp_new)
  );

  // Current byte is the final one of its group
  assign fin       = (g_idx == g_cnt - 2'd1);
  assign src.ready = !g_valid || (dst.ready && fin);
  assign take      = src.valid && src.ready;

  // Output side reads straight from the group register
  assign dst.valid    = g_valid;
  assign dst.out_last = g_last && fin;
  always_comb begin
    case (g_idx)
      2'd0:    dst.out_byte = g_bytes[0];
      2'd1:    dst.out_byte = g_bytes[1];
      2'd2:    dst.out_byte = g_bytes[2];
      default: dst.out_byte = g_bytes[0];
    endcase
  end

  // Group register: load on input transfer, step on output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
      g_idx   <= '0;
      g_cnt   <= '0;
    end else if (take) begin
      g_valid <= (grp_new.cnt != 2'd0);
      g_idx   <= '0;
      g_cnt   <= grp_new.cnt;
    end else if (dst.valid && dst.ready) begin
      if (fin) begin
        g_valid <= 1'b0;
      end else begin
        g_idx <= g_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      g_bytes <= grp_new.bytes;
      g_last  <= grp_new.last;
    end
  end

`ifndef SYNTHESIS
  // A pending group is never empty and its index stays in range
  a_grp_range: assert property (@(posedge clk) disable iff (rst)
    g_valid |-> (g_cnt != 2'd0 && g_idx < g_cnt))
    else $error("group index out of range");

  // A transfer in the middle of a group keeps the group pending
  a_grp_hold: assert property (@(posedge clk) disable iff (rst)
    (dst.valid && dst.ready && !fin) |=> (g_valid && g_idx == $past(g_idx) + 2'd1))
    else $error("group dropped before its final byte");

  // New input only overwrites a group that is finishing this cycle
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (take && g_valid) |-> (dst.ready && fin))
    else $error("group overwritten before drained");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import uripct_pkg::*;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } codec_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_item_t;

  localparam logic [127:0] HEX_UPPER   = "0123456789ABCDEF";
  localparam logic [4:0]   NOT_HEX     = 5'd16;
  localparam int           STALL_CYCLES = 300;
  localparam int           IDLE_LIMIT   = 2000;
  localparam int           SETTLE_CYCLES = 4;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  uripct_in_if  src_if ();
  uripct_out_if dst_if ();

  uri_percent_codec u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .src       (src_if),
    .dst       (dst_if)
  );

  // Predictor state: mirrors mode and the held escape bytes
  codec_mode_e mode_q;
  logic [1:0]  held_n;
  logic [7:0]  held_ch;

  out_item_t   pending_out[$];
  out_item_t   want;
  logic [7:0]  text_buf[$];
  int          mismatch_cnt = 0;
  int          idle_cycles = 0;

  // Idle control shared with the sink process
  logic        src_steady;
  logic        sink_steady;
  int          stall_asked;
  int          stall_seen = 0;
  int          stall_left = 0;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Conversion predictor helpers
  function automatic logic [4:0] hex_digit_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - 8'h30);
    if (c >= "A" && c <= "F") return 5'(c - 8'h41 + 8'd10);
    if (c >= "a" && c <= "f") return 5'(c - 8'h61 + 8'd10);
    return NOT_HEX;
  endfunction

  function automatic logic is_plain_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || c == "-" || c == "." || c == "_" || c == "~";
  endfunction

  function automatic logic [7:0] hex_up(input logic [3:0] nib);
    return HEX_UPPER[(15 - int'(nib)) * 8 +: 8];
  endfunction

  function automatic void push_out(input logic [7:0] b, input logic l);
    out_item_t item;
    item.data = b;
    item.last = l;
    pending_out.push_back(item);
  endfunction

  // Byte scanned with nothing held
  function automatic void scan_plain(input logic [7:0] b, input logic l);
    if (b == PCT_CHAR && !l) begin
      held_n = 2'd1;
    end else begin
      held_n = 2'd0;
      push_out(b, l);
    end
  endfunction

  // Expected output bytes for one accepted input byte
  function automatic void predict_byte(input logic [7:0] b, input logic l);
    logic [4:0] lo;
    logic [4:0] hi;
    if (mode_q == MODE_ENCODE) begin
      if (is_plain_char(b)) begin
        push_out(b, l);
      end else begin
        push_out(PCT_CHAR, 1'b0);
        push_out(hex_up(b[7:4]), 1'b0);
        push_out(hex_up(b[3:0]), l);
      end
    end else if (held_n == 2'd1) begin
      if (hex_digit_val(b) != NOT_HEX) begin
        if (!l) begin
          held_ch = b;
          held_n  = 2'd2;
        end else begin
          held_n = 2'd0;
          push_out(PCT_CHAR, 1'b0);
          push_out(b, 1'b1);
        end
      end else begin
        held_n = 2'd0;
        push_out(PCT_CHAR, 1'b0);
        scan_plain(b, l);
      end
    end else if (held_n == 2'd2) begin
      lo     = hex_digit_val(b);
      hi     = hex_digit_val(held_ch);
      held_n = 2'd0;
      if (lo != NOT_HEX) begin
        push_out({hi[3:0], lo[3:0]}, l);
      end else begin
        push_out(PCT_CHAR, 1'b0);
        push_out(held_ch, 1'b0);
        scan_plain(b, l);
      end
    end else begin
      // held count of 3 never occurs; it falls through as nothing held
      scan_plain(b, l);
    end
  endfunction

  // Random byte generators
  function automatic logic [7:0] rand_plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (!is_plain_char(c)) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int n;
    n = $urandom_range(21);
    if (n < 10) return 8'(8'h30 + n);
    if (n < 16) return 8'(8'h41 + n - 10);
    return 8'(8'h61 + n - 16);
  endfunction

  // Offer one byte, wait for its transfer, then predict
  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!src_steady && $urandom_range(99) < 9) begin
      src_if.valid <= 1'b0;
      @(posedge clk);
    end
    src_if.valid   <= 1'b1;
    src_if.in_byte <= b;
    src_if.in_last <= l;
    @(posedge clk);
    while (!src_if.ready) @(posedge clk);
    predict_byte(b, l);
  endtask

  // Send the buffered string, last flag on its final byte
  task automatic send_buf();
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) send_byte(text_buf[i], i == n - 1);
    text_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_buf();
  endtask

  // Mode write once the block has drained
  task automatic set_mode(input codec_mode_e m);
    src_if.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    mode_q = m;
    held_n = 2'd0;
    cfg_we <= 1'b0;
  endtask

  // Sink ready: random stalls, steady stretches, and long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      dst_if.ready <= 1'b0;
    end else if (stall_seen != stall_asked) begin
      stall_seen <= stall_asked;
      stall_left <= STALL_CYCLES;
      dst_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      dst_if.ready <= 1'b0;
    end else if (!sink_steady && $urandom_range(99) < 9) begin
      dst_if.ready <= 1'b0;
    end else begin
      dst_if.ready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest expected byte
  always @(posedge clk) begin
    if (!rst && dst_if.valid && dst_if.ready) begin
      if (pending_out.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected output: byte %02h last %0b", dst_if.out_byte, dst_if.out_last);
        mismatch_cnt++;
      end else begin
        want = pending_out.pop_front();
        if (dst_if.out_byte !== want.data || dst_if.out_last !== want.last) begin
          if (mismatch_cnt < 10)
            $display("output mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                     want.data, dst_if.out_byte, want.last, dst_if.out_last);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no input transfer
  always @(posedge clk) begin
    if (rst || (src_if.valid && src_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Encode: unreserved extremes pass, others expand, byte value extremes
  task automatic test_encode_directed();
    send_text("Az09-._~%");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Encode: random strings of random bytes
  task automatic test_encode_random(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      repeat ($urandom_range(8, 1)) text_buf.push_back(8'($urandom_range(255)));
      sent += text_buf.size();
      send_buf();
    end
  endtask

  // Sink holds off for a long stretch while the source keeps offering
  task automatic test_output_backpressure();
    stall_asked++;
    repeat (40) send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  // Decode: valid escapes, malformed escapes, flush of held bytes at string end
  task automatic test_decode_directed();
    set_mode(MODE_DECODE);
    send_text("%4f%G%%2e%");
    send_text("%4z");
    // a mode write drops a held escape
    send_byte("%", 1'b0);
    send_byte("4", 1'b0);
    set_mode(MODE_DECODE);
    send_byte("1", 1'b1);
  endtask

  // Decode: mostly well-formed escapes with random content, plus noise
  task automatic test_decode_random(input int n_bytes);
    int sent;
    int pick;
    sent = 0;
    while (sent < n_bytes) begin
      repeat ($urandom_range(6, 1)) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          text_buf.push_back(rand_plain_char());
        end else if (pick < 75) begin
          text_buf.push_back(PCT_CHAR);
          text_buf.push_back(rand_hex_char());
          text_buf.push_back(rand_hex_char());
        end else if (pick < 85) begin
          text_buf.push_back(8'($urandom_range(255)));
        end else if (pick < 93) begin
          // escape whose second digit is a random byte
          text_buf.push_back(PCT_CHAR);
          text_buf.push_back(rand_hex_char());
          text_buf.push_back(8'($urandom_range(255)));
        end else begin
          text_buf.push_back(PCT_CHAR);
        end
      end
      sent += text_buf.size();
      send_buf();
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    src_if.valid   = 1'b0;
    src_if.in_byte = 8'h00;
    src_if.in_last = 1'b0;
    mode_q         = MODE_ENCODE;
    held_n         = 2'd0;
    held_ch        = 8'h00;
    src_steady     = 1'b0;
    sink_steady    = 1'b0;
    stall_asked    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_encode_directed();
    // long stretch with no idling on either side
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    test_encode_random(60);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    test_encode_random(60);
    test_output_backpressure();
    test_decode_directed();
    test_decode_random(150);
    set_mode(MODE_ENCODE);
    test_encode_random(20);

    // drain and let any stray output show up
    src_if.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && pending_out.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
